// ----- sv/perspective_point_projection_top_defines.svh -----
// Assertion macros shared by the projection block's checker.
`ifndef PERSPECTIVE_POINT_PROJECTION_TOP_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ppp_pkg.sv -----
// Shared types, constants and helpers of the perspective projection block.
package ppp_pkg;

  localparam int LANE_W  = 21;
  localparam int REG_W   = 3 * LANE_W;
  localparam int SIZE_W  = 13;
  localparam int ADDR_W  = 6;
  localparam int CDATA_W = 64;
  localparam int MUL_W   = 46;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int T_W     = 94;
  localparam int N_W     = 110;
  localparam int Q_W     = 16;

  localparam logic [2:0] REG_POS    = 3'd0;
  localparam logic [2:0] REG_PLANE  = 3'd1;
  localparam logic [2:0] REG_HAX    = 3'd2;
  localparam logic [2:0] REG_VAX    = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  localparam logic [REG_W-1:0]  RST_POS    = 63'd0;
  localparam logic [REG_W-1:0]  RST_PLANE  = 63'd41;
  localparam logic [REG_W-1:0]  RST_HAX    = 63'd4397960527872;
  localparam logic [REG_W-1:0]  RST_VAX    = 63'd136339441844224;
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd800;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd600;

  localparam logic [Q_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [Q_W-1:0] SAT_NEG = 16'h8000;

  typedef struct packed {
    logic [REG_W-1:0]  pos;
    logic [REG_W-1:0]  plane;
    logic [REG_W-1:0]  hax;
    logic [REG_W-1:0]  vax;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } ppp_cfg_t;

  typedef struct packed {
    logic           spec;
    logic [Q_W-1:0] spec_val;
    logic           sat_hi;
    logic           sat_lo;
  } ppp_axis_side_t;

  typedef struct packed {
    logic           depth_zero;
    ppp_axis_side_t x;
    ppp_axis_side_t y;
  } ppp_side_t;

  function automatic logic signed [LANE_W-1:0] lane_get(logic [REG_W-1:0] v, int k);
    return $signed(v[LANE_W*k +: LANE_W]);
  endfunction

endpackage

// ----- sv/perspective_point_projection_top.sv -----
// Top level of the streaming perspective point projection pipeline.
// This block projects one 3D point (signed Q9.12 lanes) per clock, when the
// output is not stalled, onto the camera image plane and returns the rounded,
// saturated pixel column and row plus a flag that is set when the point lies
// in the camera plane. It is fully pipelined: a new point can be accepted in
// every cycle that the output is not stalled. The datapath has a difference
// stage, a lane multiply stage, a dot-product sum stage, two stages for the
// wide 46x46 products, a numerator stage, a stage that scales by the image
// size, a sign-normalizing stage, a range-check stage, sixteen one-bit
// restoring division stages per axis, and the output register. When the
// output is held off, the whole pipeline freezes, so no request is lost or
// repeated; in_tready follows out_tready in that case. Configuration
// registers sit at byte addresses 8*i on a 64-bit APB-style port and should
// be written only while no points are in flight. There is no clearing pass
// after reset.
module perspective_point_projection_top (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields, low bit up: point_x[20:0], point_y[41:21], point_z[62:42], pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // out_tdata fields, low bit up: screen_x[15:0], screen_y[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser fields: depth_zero[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import ppp_pkg::*;

  localparam int DW = LANE_W + 1;
  localparam int PW = 2 * DW - 1;
  localparam int SW = PW + 2;
  localparam int NSTG = Q_W;

  ppp_cfg_t cfg;
  logic     en;

  // The whole pipeline advances unless a finished result is waiting.
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign cfg_pready = 1'b1;

  ppp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg_o   (cfg)
  );

  logic signed [LANE_W-1:0] pos [3], av [3], hv [3], vv [3], pt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos[k] = lane_get(cfg.pos, k);
      av[k]  = lane_get(cfg.plane, k);
      hv[k]  = lane_get(cfg.hax, k);
      vv[k]  = lane_get(cfg.vax, k);
      pt[k]  = lane_get(in_tdata[REG_W-1:0], k);
    end
  end

  // Valid bits of the front stages.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic vd_r [NSTG];
  logic out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
      for (int s = 0; s < NSTG; s++) vd_r[s] <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r; v9_r <= v8_r;
      vd_r[0] <= v9_r;
      for (int s = 1; s < NSTG; s++) vd_r[s] <= vd_r[s-1];
      out_tvalid_r <= vd_r[NSTG-1];
    end
  end

  // Stage 1: point relative to the camera.
  logic signed [DW-1:0] d_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) d_r[k] <= DW'(pt[k]) - DW'(pos[k]);
    end
  end

  // Stage 2: lane products of every dot product needed.
  logic signed [PW-1:0] p_ad [3], p_aa [3], p_ah [3], p_dh [3], p_hh [3];
  logic signed [PW-1:0] p_av [3], p_dv [3], p_vv [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_ad[k] <= PW'(av[k]) * PW'(d_r[k]);
        p_aa[k] <= PW'(av[k]) * PW'(av[k]);
        p_ah[k] <= PW'(av[k]) * PW'(hv[k]);
        p_dh[k] <= PW'(d_r[k]) * PW'(hv[k]);
        p_hh[k] <= PW'(hv[k]) * PW'(hv[k]);
        p_av[k] <= PW'(av[k]) * PW'(vv[k]);
        p_dv[k] <= PW'(d_r[k]) * PW'(vv[k]);
        p_vv[k] <= PW'(vv[k]) * PW'(vv[k]);
      end
    end
  end

  // Stage 3: dot-product sums.
  logic signed [SW-1:0] ad_r, aa_r, ah_r, dh_r, hh_r, avd_r, dv_r, vvd_r;

  function automatic logic signed [SW-1:0] sum3(logic signed [PW-1:0] x0,
                                                logic signed [PW-1:0] x1,
                                                logic signed [PW-1:0] x2);
    return SW'(x0) + SW'(x1) + SW'(x2);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r  <= sum3(p_ad[0], p_ad[1], p_ad[2]);
      aa_r  <= sum3(p_aa[0], p_aa[1], p_aa[2]);
      ah_r  <= sum3(p_ah[0], p_ah[1], p_ah[2]);
      dh_r  <= sum3(p_dh[0], p_dh[1], p_dh[2]);
      hh_r  <= sum3(p_hh[0], p_hh[1], p_hh[2]);
      avd_r <= sum3(p_av[0], p_av[1], p_av[2]);
      dv_r  <= sum3(p_dv[0], p_dv[1], p_dv[2]);
      vvd_r <= sum3(p_vv[0], p_vv[1], p_vv[2]);
    end
  end

  // Stages 4 and 5: the wide products, with the depth flag riding alongside.
  logic signed [PROD_W-1:0] den_x, m1_x, m2_x, den_y, m1_y, m2_y;
  logic dz4_r, dz5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dz4_r <= ad_r == '0;
      dz5_r <= dz4_r;
    end
  end

  ppp_mul46 u_den_x (.clk(clk), .en(en), .a_i(MUL_W'(ad_r)), .b_i(MUL_W'(hh_r)),  .p_o(den_x));
  ppp_mul46 u_m1_x  (.clk(clk), .en(en), .a_i(MUL_W'(aa_r)), .b_i(MUL_W'(dh_r)),  .p_o(m1_x));
  ppp_mul46 u_m2_x  (.clk(clk), .en(en), .a_i(MUL_W'(ad_r)), .b_i(MUL_W'(ah_r)),  .p_o(m2_x));
  ppp_mul46 u_den_y (.clk(clk), .en(en), .a_i(MUL_W'(ad_r)), .b_i(MUL_W'(vvd_r)), .p_o(den_y));
  ppp_mul46 u_m1_y  (.clk(clk), .en(en), .a_i(MUL_W'(aa_r)), .b_i(MUL_W'(dv_r)),  .p_o(m1_y));
  ppp_mul46 u_m2_y  (.clk(clk), .en(en), .a_i(MUL_W'(ad_r)), .b_i(MUL_W'(avd_r)), .p_o(m2_y));

  // Stage 6: numerator terms. The row axis runs downward, so its term flips.
  logic signed [T_W-1:0]    tx_nxt, ty_nxt, tx6_r, ty6_r;
  logic signed [PROD_W-1:0] dx6_r, dy6_r;
  logic [Q_W-1:0]           cen_x, cen_y;
  ppp_side_t                side6_nxt, side6_r;

  assign tx_nxt = T_W'(den_x) + (T_W'(m1_x) - T_W'(m2_x));
  assign ty_nxt = T_W'(den_y) - (T_W'(m1_y) - T_W'(m2_y));
  assign cen_x  = Q_W'((14'(cfg.width) + 14'd1) >> 1);
  assign cen_y  = Q_W'((14'(cfg.height) + 14'd1) >> 1);

  // A zero denominator gives the image center for a zero term, else the
  // saturation limit on the side of the term's sign.
  always_comb begin
    side6_nxt.depth_zero = dz5_r;
    side6_nxt.x.spec     = den_x == '0;
    side6_nxt.x.spec_val = (tx_nxt == '0) ? cen_x : (tx_nxt < 0) ? SAT_NEG : SAT_POS;
    side6_nxt.x.sat_hi   = 1'b0;
    side6_nxt.x.sat_lo   = 1'b0;
    side6_nxt.y.spec     = den_y == '0;
    side6_nxt.y.spec_val = (ty_nxt == '0) ? cen_y : (ty_nxt < 0) ? SAT_NEG : SAT_POS;
    side6_nxt.y.sat_hi   = 1'b0;
    side6_nxt.y.sat_lo   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx6_r   <= tx_nxt;
      ty6_r   <= ty_nxt;
      dx6_r   <= den_x;
      dy6_r   <= den_y;
      side6_r <= side6_nxt;
    end
  end

  // Stage 7: scale the term by the image size in three partial products.
  localparam int PPW = 46;
  logic signed [PPW-1:0]    px0_r, px1_r, px2_r, py0_r, py1_r, py2_r;
  logic signed [PROD_W-1:0] dx7_r, dy7_r;
  ppp_side_t                side7_r;
  logic signed [SIZE_W:0]   sz_w, sz_h;

  assign sz_w = $signed({1'b0, cfg.width});
  assign sz_h = $signed({1'b0, cfg.height});

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r   <= PPW'($signed({1'b0, tx6_r[30:0]})) * PPW'(sz_w);
      px1_r   <= PPW'($signed({1'b0, tx6_r[61:31]})) * PPW'(sz_w);
      px2_r   <= PPW'($signed(tx6_r[T_W-1:62])) * PPW'(sz_w);
      py0_r   <= PPW'($signed({1'b0, ty6_r[30:0]})) * PPW'(sz_h);
      py1_r   <= PPW'($signed({1'b0, ty6_r[61:31]})) * PPW'(sz_h);
      py2_r   <= PPW'($signed(ty6_r[T_W-1:62])) * PPW'(sz_h);
      dx7_r   <= dx6_r;
      dy7_r   <= dy6_r;
      side7_r <= side6_r;
    end
  end

  // Stage 8: numerator size*t + den over divisor 2*den, made positive.
  logic signed [N_W-1:0] numx, numy, dvx, dvy;
  logic signed [N_W-1:0] nx8_r, ny8_r, dx8_r, dy8_r;
  ppp_side_t             side8_r;

  assign numx = (N_W'(px2_r) <<< 62) + (N_W'(px1_r) <<< 31) + N_W'(px0_r) + N_W'(dx7_r);
  assign numy = (N_W'(py2_r) <<< 62) + (N_W'(py1_r) <<< 31) + N_W'(py0_r) + N_W'(dy7_r);
  assign dvx  = N_W'(dx7_r) <<< 1;
  assign dvy  = N_W'(dy7_r) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      nx8_r   <= (dvx < 0) ? -numx : numx;
      dx8_r   <= (dvx < 0) ? -dvx  : dvx;
      ny8_r   <= (dvy < 0) ? -numy : numy;
      dy8_r   <= (dvy < 0) ? -dvy  : dvy;
      side8_r <= side7_r;
    end
  end

  // Stage 9: offset the numerator by 32768 divisors so the quotient is a
  // 16-bit unsigned value, and flag results outside the 16-bit range.
  logic signed [N_W-1:0] nbx, nby;
  logic [N_W-1:0]        rem_w [2][NSTG+1];
  logic [N_W-1:0]        dk_w  [2][NSTG+1];
  logic [Q_W-1:0]        q_w   [2][NSTG+1];
  logic [N_W-1:0]        rem9_r [2], dk9_r [2];
  ppp_side_t             side9_nxt, side9_r;

  assign nbx = nx8_r + (dx8_r <<< (Q_W - 1));
  assign nby = ny8_r + (dy8_r <<< (Q_W - 1));

  always_comb begin
    side9_nxt          = side8_r;
    side9_nxt.x.sat_hi = nbx >= (dx8_r <<< Q_W);
    side9_nxt.x.sat_lo = nbx < 0;
    side9_nxt.y.sat_hi = nby >= (dy8_r <<< Q_W);
    side9_nxt.y.sat_lo = nby < 0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem9_r[0] <= nbx;
      rem9_r[1] <= nby;
      dk9_r[0]  <= dx8_r <<< (Q_W - 1);
      dk9_r[1]  <= dy8_r <<< (Q_W - 1);
      side9_r   <= side9_nxt;
    end
  end

  // Stages 10 to 25: one quotient bit per stage for each axis.
  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    assign rem_w[ax][0] = rem9_r[ax];
    assign dk_w[ax][0]  = dk9_r[ax];
    assign q_w[ax][0]   = '0;
    for (genvar s = 0; s < NSTG; s++) begin : g_stage
      ppp_div_stage u_div (
        .clk   (clk),
        .en    (en),
        .rem_i (rem_w[ax][s]),
        .dk_i  (dk_w[ax][s]),
        .q_i   (q_w[ax][s]),
        .rem_o (rem_w[ax][s+1]),
        .dk_o  (dk_w[ax][s+1]),
        .q_o   (q_w[ax][s+1])
      );
    end
  end

  ppp_side_t side_d_r [NSTG];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= side9_r;
      for (int s = 1; s < NSTG; s++) side_d_r[s] <= side_d_r[s-1];
    end
  end

  // Output register: pick the special value, a limit, or the quotient
  // moved back down by 32768.
  function automatic logic [Q_W-1:0] axis_pick(ppp_axis_side_t sd, logic [Q_W-1:0] q);
    if (sd.spec)        return sd.spec_val;
    else if (sd.sat_hi) return SAT_POS;
    else if (sd.sat_lo) return SAT_NEG;
    else                return {~q[Q_W-1], q[Q_W-2:0]};
  endfunction

  logic [31:0] out_tdata_r;
  logic        out_tuser_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {axis_pick(side_d_r[NSTG-1].y, q_w[1][NSTG]),
                      axis_pick(side_d_r[NSTG-1].x, q_w[0][NSTG])};
      out_tuser_r <= side_d_r[NSTG-1].depth_zero;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Unused remainder and divisor outputs of the last division stage.
  logic unused_tail;
  assign unused_tail = ^{rem_w[0][NSTG], rem_w[1][NSTG], dk_w[0][NSTG], dk_w[1][NSTG],
                         in_tdata[63]};

endmodule

// ----- sv/ppp_cfg.sv -----
// Configuration register file with an APB-style access port.
module ppp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppp_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppp_pkg::CDATA_W-1:0] pwdata,
  output logic [ppp_pkg::CDATA_W-1:0] prdata,
  output ppp_pkg::ppp_cfg_t           cfg_o
);
  import ppp_pkg::*;

  ppp_cfg_t   cfg_r, cfg_nxt;
  logic [2:0] idx;

  assign idx = paddr[5:3];

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_POS:    cfg_nxt.pos    = pwdata[REG_W-1:0];
        REG_PLANE:  cfg_nxt.plane  = pwdata[REG_W-1:0];
        REG_HAX:    cfg_nxt.hax    = pwdata[REG_W-1:0];
        REG_VAX:    cfg_nxt.vax    = pwdata[REG_W-1:0];
        REG_WIDTH:  cfg_nxt.width  = pwdata[SIZE_W-1:0];
        REG_HEIGHT: cfg_nxt.height = pwdata[SIZE_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pos: RST_POS, plane: RST_PLANE, hax: RST_HAX, vax: RST_VAX,
                 width: RST_WIDTH, height: RST_HEIGHT};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_POS:    prdata = CDATA_W'(cfg_r.pos);
      REG_PLANE:  prdata = CDATA_W'(cfg_r.plane);
      REG_HAX:    prdata = CDATA_W'(cfg_r.hax);
      REG_VAX:    prdata = CDATA_W'(cfg_r.vax);
      REG_WIDTH:  prdata = CDATA_W'(cfg_r.width);
      REG_HEIGHT: prdata = CDATA_W'(cfg_r.height);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

// ----- sv/ppp_mul46.sv -----
// Two-stage signed 46x46 multiplier built from four registered partial products.
module ppp_mul46 (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [ppp_pkg::MUL_W-1:0]   a_i,
  input  logic signed [ppp_pkg::MUL_W-1:0]   b_i,
  output logic signed [ppp_pkg::PROD_W-1:0]  p_o
);
  import ppp_pkg::*;

  localparam int HW = MUL_W / 2;

  logic signed [HW:0]          al, bl;
  logic signed [HW-1:0]        ah, bh;
  logic signed [2*HW+1:0]      ll_r;
  logic signed [2*HW:0]        lh_r, hl_r;
  logic signed [2*HW-1:0]      hh_r;
  logic signed [PROD_W-1:0]    p_r, p_nxt;

  assign al = $signed({1'b0, a_i[HW-1:0]});
  assign bl = $signed({1'b0, b_i[HW-1:0]});
  assign ah = a_i[MUL_W-1:HW];
  assign bh = b_i[MUL_W-1:HW];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= (2*HW+2)'(al) * (2*HW+2)'(bl);
      lh_r <= (2*HW+1)'(al) * (2*HW+1)'(bh);
      hl_r <= (2*HW+1)'(ah) * (2*HW+1)'(bl);
      hh_r <= (2*HW)'(ah) * (2*HW)'(bh);
    end
  end

  assign p_nxt = (PROD_W'(hh_r) <<< (2*HW))
               + ((PROD_W'(lh_r) + PROD_W'(hl_r)) <<< HW)
               + PROD_W'(ll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

// ----- sv/ppp_div_stage.sv -----
// One registered step of a restoring division that yields one quotient bit.
module ppp_div_stage (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ppp_pkg::N_W-1:0]      rem_i,
  input  logic [ppp_pkg::N_W-1:0]      dk_i,
  input  logic [ppp_pkg::Q_W-1:0]      q_i,
  output logic [ppp_pkg::N_W-1:0]      rem_o,
  output logic [ppp_pkg::N_W-1:0]      dk_o,
  output logic [ppp_pkg::Q_W-1:0]      q_o
);
  import ppp_pkg::*;

  logic [N_W-1:0] rem_r, dk_r;
  logic [Q_W-1:0] q_r;
  logic           ge;

  assign ge = rem_i >= dk_i;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? rem_i - dk_i : rem_i;
      dk_r  <= dk_i >> 1;
      q_r   <= {q_i[Q_W-2:0], ge};
    end
  end

  assign rem_o = rem_r;
  assign dk_o  = dk_r;
  assign q_o   = q_r;

endmodule

// ----- sv/ppp_checker.sv -----
// Port-level checker of the projection block, bound to its top level.
`include "perspective_point_projection_top_defines.svh"

module ppp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [5:0]  cfg_paddr,
  input logic [63:0] cfg_pwdata,
  input logic [63:0] cfg_prdata,
  input logic        cfg_pready
);

  // A stalled result keeps its valid and its payload.
  `PPP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tuser),
                  "stalled result changed")

  // The input side is held off exactly while a finished result waits.
  `PPP_ASSERT_IMP(a_ready_link, 1'b1, in_tready == (!out_tvalid || out_tready),
                  "input ready does not follow the output stall")

  // A vector register written in a cycle reads back its value in the next.
  `PPP_ASSERT_NXT(a_cfg_readback,
                  cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[5],
                  !(cfg_psel && !cfg_pwrite && cfg_paddr == $past(cfg_paddr)) ||
                  cfg_prdata == {1'b0, $past(cfg_pwdata[62:0])},
                  "configuration readback mismatch")

  logic unused_ports;
  assign unused_ports = ^{in_tvalid, in_tdata};

endmodule

bind perspective_point_projection_top ppp_checker u_ppp_checker (.*);
